FILE: rtl/sdo_pkg.sv
// ----------------------------------------------------------------------------
// sdo_pkg
// shared types, codes and constants of the sdo client transfer engine
// ----------------------------------------------------------------------------
package sdo_pkg;

	localparam int BUFFER_BYTES_DEF = 256;
	localparam int TIMEOUT_W        = 13;
	localparam int LEN_W            = 9;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 13'd1000;
	localparam logic [31:0]          TIMEOUT_ABORT = 32'h0504_0000;

	// host action codes
	localparam logic [2:0] ACT_LOAD  = 3'd0;
	localparam logic [2:0] ACT_READ  = 3'd1;
	localparam logic [2:0] ACT_WRITE = 3'd2;
	localparam logic [2:0] ACT_FRAME = 3'd3;
	localparam logic [2:0] ACT_TICK  = 3'd4;

	// result kinds
	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_DONE  = 2'd1;
	localparam logic [1:0] KIND_BYTE  = 2'd2;

	// command specifiers
	localparam logic [7:0] CS_UPLOAD_INIT = 8'h40;
	localparam logic [7:0] CS_DL_EMPTY    = 8'h22;
	localparam logic [7:0] CS_DL_EXP      = 8'h23;
	localparam logic [7:0] CS_DL_SEG_INIT = 8'h21;
	localparam logic [7:0] CS_ABORT       = 8'h80;
	localparam logic [2:0] SCS_UL_SEG     = 3'b000;
	localparam logic [2:0] SCS_DL_SEG     = 3'b001;
	localparam logic [2:0] SCS_UL_INIT    = 3'b010;
	localparam logic [2:0] SCS_DL_INIT    = 3'b011;
	localparam logic [2:0] CCS_UL_SEG     = 3'b011;

	localparam logic [3:0] TX_ID_HI = 4'hC; // 0x600 + node
	localparam logic [3:0] RX_ID_HI = 4'hB; // 0x580 + node

	typedef struct packed {
		logic [2:0]  action;
		logic [6:0]  node;
		logic [15:0] object_index;
		logic [7:0]  object_sub;
		logic [7:0]  data_byte;
		logic [7:0]  byte_pos;
		logic [10:0] rx_id;
		logic [63:0] rx_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic [10:0] tx_id;
		logic [63:0] tx_data;
		logic        status;
		logic        was_write;
		logic [31:0] abort_word;
		logic [8:0]  data_length;
		logic [7:0]  byte_value;
	} out_item_t;

	typedef struct packed {
		logic capture;
		logic decode;
		logic write_step;
		logic read_step;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic dec_write;
		logic dec_read;
		logic dec_result;
		logic wr_last;
		logic plan_read;
		logic plan_result;
		logic rd_done;
	} dp_sts_t;

endpackage

FILE: rtl/sdo_ram.sv
// ----------------------------------------------------------------------------
// sdo_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sdo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/sdo_ctrl.sv
// ----------------------------------------------------------------------------
// sdo_ctrl
// sequencer: accept, decode, store write loop, store read loop, result
// ----------------------------------------------------------------------------
module sdo_ctrl
	import sdo_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output dp_cmd_t cmd,
	input  dp_sts_t sts
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DECODE = 5'b00010,
		S_WRITE  = 5'b00100,
		S_READ   = 5'b01000,
		S_EMIT   = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = in_valid;
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.dec_write)       state_d = S_WRITE;
				else if (sts.dec_read)   state_d = S_READ;
				else if (sts.dec_result) state_d = S_EMIT;
				else                     state_d = S_IDLE;
			end
			S_WRITE: begin
				cmd.write_step = 1'b1;
				if (sts.wr_last) begin
					if (sts.plan_read)        state_d = S_READ;
					else if (sts.plan_result) state_d = S_EMIT;
					else                      state_d = S_IDLE;
				end
			end
			S_READ: begin
				cmd.read_step = 1'b1;
				if (sts.rd_done) state_d = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = out_free;
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)       out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/sdo_dp.sv
// ----------------------------------------------------------------------------
// sdo_dp
// transfer state, request decode, data store and result register
// ----------------------------------------------------------------------------
module sdo_dp
	import sdo_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  in_item_t             in_item,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_data,
	output out_item_t            out_item
);

	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam int AW = $clog2(BUFFER_BYTES);

	function automatic logic [63:0] head_bytes(input logic [7:0] cs, input logic [15:0] idx,
			input logic [7:0] sub);
		head_bytes = {32'h0, sub, idx[15:8], idx[7:0], cs};
	endfunction

	// architectural state
	in_item_t             in_q;
	logic [TIMEOUT_W-1:0] timeout_q, time_left_q;
	logic                 busy_q, writing_q, segmented_q, toggle_q;
	logic [6:0]           node_q;
	logic [CW-1:0]        load_count_q, send_off_q, read_count_q;

	// per item plan
	logic [2:0]  wn_q, wb_q, rn_q, rb_q, k_q;
	logic        wsrc_load_q, result_q, failed_q, was_write_q;
	logic [1:0]  kind_q;
	logic [CW-1:0] rbase_q;
	logic [31:0] code_q;
	logic [63:0] acc_q;
	logic        cap_en_s1;
	logic [2:0]  cap_pos_s1;
	out_item_t   out_q, out_d;

	// decode
	logic                 d_result, d_failed, d_finish, d_seg_wr, d_seg_rd, d_wsrc_load;
	logic [1:0]           d_kind;
	logic [2:0]           d_wn, d_wb, d_rn, d_rb, seg_t_len, chunk;
	logic                 seg_t;
	logic [CW-1:0]        d_rbase, remaining;
	logic [63:0]          d_head;
	logic [31:0]          d_code;
	logic                 n_busy, n_writing, n_segmented, n_toggle;
	logic [6:0]           n_node;
	logic [TIMEOUT_W-1:0] n_time;
	logic [CW-1:0]        n_load, n_send, n_read;
	logic [7:0]           rcs;

	assign rcs = in_q.rx_data[7:0];
	assign remaining = load_count_q - send_off_q;
	assign chunk = (remaining < CW'(7)) ? remaining[2:0] : 3'd7;
	assign seg_t_len = 3'd7 - chunk;

	always_comb begin
		d_result = 1'b0; d_kind = KIND_FRAME; d_failed = 1'b0; d_code = '0;
		d_finish = 1'b0; d_seg_wr = 1'b0; d_seg_rd = 1'b0; seg_t = 1'b0;
		d_wn = '0; d_wb = '0; d_wsrc_load = 1'b0;
		d_rn = '0; d_rb = '0; d_rbase = '0; d_head = '0;
		n_busy = busy_q; n_writing = writing_q; n_segmented = segmented_q;
		n_toggle = toggle_q; n_node = node_q; n_time = time_left_q;
		n_load = load_count_q; n_send = send_off_q; n_read = read_count_q;
		unique case (in_q.action) inside
			ACT_LOAD: begin
				d_wn = busy_q ? 3'd0 : 3'd1;
				d_wsrc_load = 1'b1;
			end
			ACT_READ, ACT_WRITE: begin
				if (!busy_q) begin
					n_busy = 1'b1;
					n_writing = (in_q.action == ACT_WRITE);
					n_segmented = 1'b0;
					n_toggle = 1'b0;
					n_node = in_q.node;
					n_send = '0;
					d_result = 1'b1;
					if (in_q.action == ACT_READ) begin
						n_read = '0;
						n_load = '0;
						d_head = head_bytes(CS_UPLOAD_INIT, in_q.object_index, in_q.object_sub);
					end else if (load_count_q == '0) begin
						d_head = head_bytes(CS_DL_EMPTY, in_q.object_index, in_q.object_sub);
					end else if (load_count_q <= CW'(4)) begin
						d_head = head_bytes(CS_DL_EXP | {4'h0, 2'(3'd4 - load_count_q[2:0]), 2'b00},
							in_q.object_index, in_q.object_sub);
						d_rn = load_count_q[2:0];
						d_rb = 3'd4;
					end else begin
						n_segmented = 1'b1;
						d_head = head_bytes(CS_DL_SEG_INIT, in_q.object_index, in_q.object_sub)
							| {32'(load_count_q), 32'h0};
					end
				end
			end
			ACT_FRAME: begin
				if (busy_q && in_q.rx_id == {RX_ID_HI, node_q}) begin
					if (rcs == CS_ABORT) begin
						d_finish = 1'b1; d_failed = 1'b1; d_code = in_q.rx_data[63:32];
					end else if (writing_q) begin
						if (rcs[7:5] == SCS_DL_INIT) begin
							if (segmented_q && send_off_q < load_count_q) begin
								d_seg_wr = 1'b1; seg_t = 1'b0;
							end else d_finish = 1'b1;
						end else if (rcs[7:5] == SCS_DL_SEG) begin
							if (!segmented_q || send_off_q >= load_count_q) d_finish = 1'b1;
							else begin
								d_seg_wr = 1'b1; seg_t = !toggle_q;
							end
						end else begin
							d_finish = 1'b1; d_failed = 1'b1;
						end
					end else if (rcs[7:5] == SCS_UL_INIT) begin
						if (rcs[1]) begin
							// expedited upload lands at the start of the store
							d_wn = rcs[0] ? 3'd4 - {1'b0, rcs[3:2]} : 3'd4;
							d_wb = 3'd4;
							n_read = '0;
							d_finish = 1'b1;
						end else begin
							n_read = '0;
							d_seg_rd = 1'b1; seg_t = 1'b0;
						end
					end else if (rcs[7:5] == SCS_UL_SEG) begin
						d_wn = 3'd7 - rcs[3:1];
						d_wb = 3'd1;
						if (rcs[0]) d_finish = 1'b1;
						else begin
							d_seg_rd = 1'b1; seg_t = !toggle_q;
						end
					end else begin
						d_finish = 1'b1; d_failed = 1'b1;
					end
				end
			end
			ACT_TICK: begin
				if (busy_q) begin
					if (time_left_q <= TIMEOUT_W'(1)) begin
						d_finish = 1'b1; d_failed = 1'b1; d_code = TIMEOUT_ABORT;
					end else n_time = time_left_q - TIMEOUT_W'(1);
				end else begin
					d_result = 1'b1;
					d_kind = KIND_BYTE;
					d_rn = (32'(in_q.byte_pos) < BUFFER_BYTES) ? 3'd1 : 3'd0;
					d_rbase = CW'(in_q.byte_pos);
				end
			end
			default: ;
		endcase
		if (d_seg_wr) begin
			n_toggle = seg_t;
			d_result = 1'b1;
			d_head = {56'h0, 3'b000, seg_t, seg_t_len, remaining <= CW'(7)};
			d_rn = chunk; d_rb = 3'd1; d_rbase = send_off_q;
			n_send = send_off_q + CW'(chunk);
		end
		if (d_seg_rd) begin
			n_toggle = seg_t;
			d_result = 1'b1;
			d_head = {56'h0, CCS_UL_SEG, seg_t, 4'h0};
		end
		if (d_result && d_kind == KIND_FRAME) n_time = timeout_q;
		if (d_finish) begin
			d_result = 1'b1; d_kind = KIND_DONE;
			n_busy = 1'b0; n_writing = 1'b0; n_segmented = 1'b0; n_toggle = 1'b0;
			n_time = '0; n_send = '0; n_load = '0;
		end
	end

	// store access
	logic [CW-1:0] wptr;
	logic          wr_ok, ram_we, ram_re;
	logic [2:0]    wsel;
	logic [7:0]    wdata, rdata;

	assign wptr   = wsrc_load_q ? load_count_q : read_count_q;
	assign wr_ok  = wptr < CW'(BUFFER_BYTES);
	assign ram_we = cmd.write_step && wr_ok;
	assign wsel   = wb_q + k_q;
	assign wdata  = wsrc_load_q ? in_q.data_byte : in_q.rx_data[8*wsel +: 8];
	assign ram_re = cmd.read_step && (k_q < rn_q);

	sdo_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wptr[AW-1:0]),
		.wdata (wdata),
		.re    (ram_re),
		.raddr (AW'(rbase_q + CW'(k_q))),
		.rdata (rdata)
	);

	assign sts.dec_write   = (d_wn != '0);
	assign sts.dec_read    = (d_rn != '0);
	assign sts.dec_result  = d_result;
	assign sts.wr_last     = (k_q == wn_q - 3'd1);
	assign sts.plan_read   = (rn_q != '0);
	assign sts.plan_result = result_q;
	assign sts.rd_done     = (k_q == rn_q);

	// result fields, those of other kinds stay 0
	always_comb begin
		out_d = '0;
		out_d.out_kind = kind_q;
		unique case (kind_q)
			KIND_FRAME: begin
				out_d.tx_id   = {TX_ID_HI, node_q};
				out_d.tx_data = acc_q;
			end
			KIND_DONE: begin
				out_d.status      = failed_q;
				out_d.was_write   = was_write_q;
				out_d.abort_word  = code_q;
				out_d.data_length = (!failed_q && !was_write_q) ? LEN_W'(read_count_q) : '0;
			end
			KIND_BYTE: out_d.byte_value = acc_q[7:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q    <= TIMEOUT_RESET;
			busy_q       <= 1'b0;
			writing_q    <= 1'b0;
			segmented_q  <= 1'b0;
			toggle_q     <= 1'b0;
			node_q       <= '0;
			time_left_q  <= '0;
			load_count_q <= '0;
			send_off_q   <= '0;
			read_count_q <= '0;
			k_q          <= '0;
			cap_en_s1    <= 1'b0;
		end else begin
			cap_en_s1 <= ram_re;
			if (cfg_we) timeout_q <= cfg_data;
			if (cmd.decode) begin
				busy_q <= n_busy; writing_q <= n_writing; segmented_q <= n_segmented;
				toggle_q <= n_toggle; node_q <= n_node; time_left_q <= n_time;
				load_count_q <= n_load; send_off_q <= n_send; read_count_q <= n_read;
				k_q <= '0;
			end
			if (cmd.write_step) begin
				if (wr_ok) begin
					if (wsrc_load_q) load_count_q <= load_count_q + CW'(1);
					else             read_count_q <= read_count_q + CW'(1);
				end
				k_q <= sts.wr_last ? 3'd0 : k_q + 3'd1;
			end
			if (ram_re) k_q <= k_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) in_q <= in_item;
		cap_pos_s1 <= rb_q + k_q;
		if (cmd.decode) begin
			wn_q <= d_wn; wb_q <= d_wb; wsrc_load_q <= d_wsrc_load;
			rn_q <= d_rn; rb_q <= d_rb; rbase_q <= d_rbase;
			result_q <= d_result; kind_q <= d_kind; failed_q <= d_failed;
			code_q <= d_code; was_write_q <= writing_q;
			acc_q <= d_head;
		end else if (cap_en_s1) begin
			acc_q[8*cap_pos_s1 +: 8] <= rdata;
		end
		if (cmd.emit) out_q <= out_d;
	end

	assign out_item = out_q;

endmodule

FILE: rtl/sdo_client_transfer.sv
// ----------------------------------------------------------------------------
// sdo_client_transfer
// canopen sdo client transfer engine: expedited and segmented up/download
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready/in_item carry one host request per handshake: load a
//   write byte, start a read, start a write, a received can frame or a
//   millisecond tick (read back of a store byte when no transfer runs)
//   out_valid/out_ready/out_item carry at most one result per request: a
//   frame to send on 0x600+node, a finished transfer, or a read back byte
//   cfg_valid/cfg_ready/cfg_data write the timeout in ticks (reset 1000);
//   write it only while no transfer request is in flight
// timing
//   one request at a time; a request is accepted and decoded, then takes a
//   write step per byte moved into the store, a read step per store byte read
//   and a closing read step when bytes are read, and an emit step when a result
//   goes out, all set by the single store port stepping one byte a cycle
//   the result sits in an output register, so the next request is taken
//   while an earlier result still waits; a stalled receiver holds the block
//   only when a new result is ready to go out
// reset
//   asynchronous, active low; the engine returns idle with nothing in flight;
//   the data store keeps its contents and needs no clearing
// ----------------------------------------------------------------------------
module sdo_client_transfer
	import sdo_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TIMEOUT_W-1:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// config is always taken, each write goes straight into the timeout register
	assign cfg_ready = 1'b1;

	sdo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// transfer state, store and result register
	sdo_dp #(.BUFFER_BYTES(BUFFER_BYTES)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_item (out_item)
	);

endmodule

FILE: rtl/sdo_checker.sv
// ----------------------------------------------------------------------------
// sdo_checker
// port level checks of the sdo client transfer engine
// ----------------------------------------------------------------------------
module sdo_checker
	import sdo_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.out_kind == KIND_FRAME || out_item.out_kind == KIND_DONE ||
			out_item.out_kind == KIND_BYTE)
		else $error("result kind out of range");

	a_tx_id: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.out_kind == KIND_FRAME |-> out_item.tx_id[10:7] == TX_ID_HI)
		else $error("request frame not on 0x600 plus node");

endmodule

bind sdo_client_transfer sdo_checker u_sdo_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

FILE: tb/tb_sdo_client_transfer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sdo_client_transfer
// self-checking bench: a server emulator drives up/download transfers into
// the sdo client while a scoreboard predicts every frame, finish and byte
// ----------------------------------------------------------------------------
module tb_sdo_client_transfer;
	import sdo_pkg::*;

	localparam int STORE_BYTES = 256;
	localparam int IDLE_LIMIT  = 3000;   // cycles with no handshake at all
	localparam int DRAIN_WAIT  = 30;     // covers the longest request

	// scoreboard: own copy of the client state, predicts each result
	class sdo_scoreboard;
		bit [12:0]   timeout_ticks;
		bit          busy, writing, segmented, toggle;
		bit [6:0]    node;
		bit [15:0]   index;
		bit [7:0]    sub;
		int unsigned time_left, load_count, send_offset, read_count;
		bit [31:0]   announced;
		bit [7:0]    store [STORE_BYTES];
		bit          written [STORE_BYTES];
		out_item_t   expected_q [$];
		int          errors;

		function new();
			timeout_ticks = TIMEOUT_RESET;
		endfunction

		function out_item_t frame_out(bit [63:0] d);
			out_item_t e;
			e = '0;
			e.out_kind = KIND_FRAME;
			e.tx_id = 11'h600 + {4'b0, node};
			e.tx_data = d;
			time_left = timeout_ticks;
			return e;
		endfunction

		function out_item_t finish_out(bit failed, bit [31:0] code);
			out_item_t e;
			e = '0;
			e.out_kind = KIND_DONE;
			e.status = failed;
			e.was_write = writing;
			e.abort_word = code;
			if (!failed && !writing) e.data_length = read_count[8:0];
			busy = 0; writing = 0; segmented = 0; toggle = 0;
			time_left = 0; send_offset = 0; load_count = 0; announced = 0;
			return e;
		endfunction

		function bit [63:0] head(bit [7:0] cmd);
			return {32'h0, sub, index, cmd};
		endfunction

		function out_item_t next_segment();
			int unsigned remaining, chunk, p;
			bit [63:0] d;
			if (writing) begin
				remaining = load_count > send_offset ? load_count - send_offset : 0;
				chunk = remaining < 7 ? remaining : 7;
				d = 64'(((7 - chunk) << 1) | (toggle ? 8'h10 : 8'h00) | (remaining <= 7 ? 1 : 0));
				for (int i = 0; i < chunk; i++) begin
					p = send_offset + i;
					if (p < STORE_BYTES) d[8*(1+i) +: 8] = store[p];
				end
				send_offset += chunk;
			end else begin
				d = 64'(8'h60 | (toggle ? 8'h10 : 8'h00));
			end
			return frame_out(d);
		endfunction

		function out_item_t server_reply(bit [63:0] d);
			bit [7:0]    cmd, scs;
			int unsigned len, count;
			cmd = d[7:0];
			scs = cmd & 8'hE0;
			if (cmd == CS_ABORT) return finish_out(1, d[63:32]);
			if (writing) begin
				if (scs == 8'h60) begin
					if (segmented && send_offset < load_count) begin
						toggle = 0;
						return next_segment();
					end
					return finish_out(0, 0);
				end
				if (scs == 8'h20) begin
					if (!segmented || send_offset >= load_count) return finish_out(0, 0);
					toggle = !toggle;
					return next_segment();
				end
				return finish_out(1, 0);
			end
			if (scs == 8'h40) begin
				// expedited upload: data sits in bytes 4..7
				if (cmd[1]) begin
					len = cmd[0] ? 4 - cmd[3:2] : 4;
					for (int i = 0; i < len; i++) begin
						store[i] = d[8*(4+i) +: 8];
						written[i] = 1;
					end
					read_count = len;
					return finish_out(0, 0);
				end
				if (cmd[0]) announced = d[63:32];
				read_count = 0;
				toggle = 0;
				return next_segment();
			end
			if (scs == 8'h00) begin
				count = 7 - cmd[3:1];
				for (int i = 0; i < count; i++) begin
					// bytes past the store are dropped
					if (read_count < STORE_BYTES) begin
						store[read_count] = d[8*(1+i) +: 8];
						written[read_count] = 1;
						read_count++;
					end
				end
				if (cmd[0]) return finish_out(0, 0);
				toggle = !toggle;
				return next_segment();
			end
			return finish_out(1, 0);
		endfunction

		function bit predict(in_item_t it, output out_item_t e);
			bit [63:0] d;
			e = '0;
			case (it.action) inside
				ACT_LOAD: begin
					if (!busy && load_count < STORE_BYTES) begin
						store[load_count] = it.data_byte;
						written[load_count] = 1;
						load_count++;
					end
					return 0;
				end
				ACT_READ, ACT_WRITE: begin
					if (busy) return 0;
					busy = 1;
					writing = (it.action == ACT_WRITE);
					segmented = 0; toggle = 0;
					node = it.node; index = it.object_index; sub = it.object_sub;
					send_offset = 0; announced = 0;
					if (!writing) begin
						read_count = 0;
						load_count = 0;
						e = frame_out(head(CS_UPLOAD_INIT));
					end else if (load_count == 0) begin
						e = frame_out(head(CS_DL_EMPTY));
					end else if (load_count <= 4) begin
						d = head(8'(CS_DL_EXP | ((4 - load_count) << 2)));
						for (int i = 0; i < load_count; i++) d[8*(4+i) +: 8] = store[i];
						e = frame_out(d);
					end else begin
						segmented = 1;
						e = frame_out(head(CS_DL_SEG_INIT) | (64'(load_count) << 32));
					end
					return 1;
				end
				ACT_FRAME: begin
					if (!busy || it.rx_id != 11'h580 + {4'b0, node}) return 0;
					e = server_reply(it.rx_data);
					return 1;
				end
				ACT_TICK: begin
					if (busy) begin
						if (time_left <= 1) begin
							e = finish_out(1, TIMEOUT_ABORT);
							return 1;
						end
						time_left--;
						return 0;
					end
					e.out_kind = KIND_BYTE;
					e.byte_value = store[it.byte_pos];
					return 1;
				end
				default: return 0;
			endcase
		endfunction

		function void note_request(in_item_t it);
			out_item_t e;
			if (predict(it, e)) expected_q = {expected_q, e};
		endfunction

		function void check_result(out_item_t o);
			out_item_t e;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", o);
				return;
			end
			e = expected_q[0];
			expected_q.delete(0);
			if (o.out_kind !== e.out_kind || o.tx_id !== e.tx_id || o.tx_data !== e.tx_data ||
			    o.status !== e.status || o.was_write !== e.was_write ||
			    o.abort_word !== e.abort_word || o.data_length !== e.data_length ||
			    o.byte_value !== e.byte_value) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch kind %0d/%0d id %h/%h data %h/%h st %b/%b wr %b/%b",
						e.out_kind, o.out_kind, e.tx_id, o.tx_id, e.tx_data, o.tx_data,
						e.status, o.status, e.was_write, o.was_write);
					$display("  abort %h/%h len %0d/%0d byte %h/%h", e.abort_word,
						o.abort_word, e.data_length, o.data_length, e.byte_value,
						o.byte_value);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	in_item_t             in_item;
	logic                 out_valid;
	logic                 out_ready;
	out_item_t            out_item;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [TIMEOUT_W-1:0] cfg_data;

	sdo_scoreboard sb = new();
	int  n_items;      // accepted requests, decide the hold-off, pause, quiet part and stop
	bit  quiet;        // last part of the run: no idling on either side
	bit  held;
	bit  paused;
	int  idle_cycles;

	sdo_client_transfer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
	end

	// result side: everything is stable between the falling and the rising edge,
	// so a handshake seen at the falling edge is taken at the next rising edge
	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_item);
	end

	// watchdog on cycles where no channel moves anything
	always @(negedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// receiver: random stall bursts, one long hold-off so the block backs up
	initial begin
		@(posedge clk);
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && n_items >= 350) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!quiet && $urandom_range(0, 99) < 12) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic in_item_t any_request(logic [2:0] action);
		in_item_t it;
		it.action = action;
		it.node = 7'($urandom);
		it.object_index = 16'($urandom);
		it.object_sub = 8'($urandom);
		it.data_byte = 8'($urandom);
		it.byte_pos = 8'($urandom);
		it.rx_id = 11'($urandom);
		it.rx_data = {$urandom, $urandom};
		return it;
	endfunction

	// one request through the handshake; valid stays up unless a gap follows
	task automatic send(in_item_t it);
		bit rdy;
		in_valid <= 1'b1;
		in_item <= it;
		forever begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
			if (rdy) break;
		end
		sb.note_request(it);
		n_items++;
		if (!quiet && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task automatic load(bit [7:0] b);
		in_item_t it;
		it = any_request(ACT_LOAD);
		it.data_byte = b;
		send(it);
	endtask

	task automatic start(bit wr, bit [6:0] nd, bit [15:0] idx, bit [7:0] sb_idx);
		in_item_t it;
		it = any_request(wr ? ACT_WRITE : ACT_READ);
		it.node = nd;
		it.object_index = idx;
		it.object_sub = sb_idx;
		send(it);
	endtask

	// server response on 0x580 + current node
	task automatic reply(bit [7:0] cmd);
		in_item_t it;
		it = any_request(ACT_FRAME);
		it.rx_id = 11'h580 + {4'b0, sb.node};
		it.rx_data[7:0] = cmd;
		send(it);
	endtask

	task automatic tick(bit [7:0] pos);
		in_item_t it;
		it = any_request(ACT_TICK);
		it.byte_pos = pos;
		send(it);
	endtask

	// idle read back, only of store bytes that hold data
	task automatic read_back_some();
		int p;
		repeat ($urandom_range(0, 3)) begin
			p = $urandom_range(0, STORE_BYTES - 1);
			for (int j = 0; j < STORE_BYTES; j++) begin
				if (sb.written[(p + j) % STORE_BYTES]) begin
					tick(8'((p + j) % STORE_BYTES));
					break;
				end
			end
		end
	endtask

	// write the timeout only with nothing in flight
	task automatic set_timeout(bit [12:0] v);
		bit rdy;
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		forever begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
			if (rdy) break;
		end
		cfg_valid <= 1'b0;
		sb.timeout_ticks = v;
	endtask

	// one full transfer with an emulated server; mostly well formed responses,
	// some aborts, bad specifiers and unrelated traffic mixed in, or only ticks until it expires
	task automatic run_transfer(bit let_expire);
		int  n, r, target, got, seg;
		bit  first, last;
		bit  [7:0] cmd;
		in_item_t it;
		r = $urandom_range(0, 99);
		n = r < 55 ? $urandom_range(0, 4) : r < 90 ? $urandom_range(5, 30)
		                                           : $urandom_range(31, 260);
		repeat (n) load(8'($urandom));
		start(1'($urandom_range(0, 1)), 7'($urandom), 16'($urandom), 8'($urandom));
		target = $urandom_range(0, 99) < 8 ? 300 : $urandom_range(0, 40);
		got = 0;
		first = 1;
		while (sb.busy) begin
			r = $urandom_range(0, 99);
			if (let_expire) begin
				tick(8'($urandom));
			end else if (r < 2) begin
				reply(CS_ABORT);
			end else if (r < 4) begin
				reply(8'(($urandom_range(5, 7) << 5) | $urandom_range(0, 31)));
			end else if (r < 10) begin
				case ($urandom_range(0, 4))
					0: begin
						it = any_request(ACT_FRAME);
						if (it.rx_id == 11'h580 + {4'b0, sb.node}) it.rx_id[0] = ~it.rx_id[0];
						send(it);
					end
					1: tick(8'($urandom));
					2: send(any_request(3'($urandom_range(5, 7))));
					3: load(8'($urandom));
					default: start(1'($urandom_range(0, 1)), 7'($urandom), 16'($urandom),
						8'($urandom));
				endcase
			end else if (sb.writing) begin
				cmd = 8'((sb.send_offset == 0 ? 8'h60 : 8'h20) | $urandom_range(0, 31));
				reply(cmd);
			end else if (first) begin
				first = 0;
				case ($urandom_range(0, 3))
					0: reply(8'(8'h43 | ($urandom_range(0, 3) << 2)));
					1: reply(8'(8'h42 | ($urandom_range(0, 3) << 2)));
					2: reply(8'h41);
					default: reply(8'h40);
				endcase
			end else begin
				seg = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 7);
				last = got + seg >= target;
				got += seg;
				reply(8'(last | ((7 - seg) << 1) | ($urandom_range(0, 1) << 4)));
			end
		end
		read_back_some();
	endtask

	task automatic run_until(int stop, bit allow_expiry);
		bit expire;
		while (n_items < stop) begin
			expire = allow_expiry && sb.timeout_ticks <= 60 && $urandom_range(0, 99) < 20;
			run_transfer(expire);
			// sender pause: let every outstanding result come back
			if (!paused && n_items >= 600) begin
				paused = 1;
				in_valid <= 1'b0;
				while (sb.expected_q.size() != 0) @(posedge clk);
			end
			if (n_items >= 1000) quiet = 1;
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_timeout(13'd10);

		// directed: byte extremes, expedited write, empty write answered by a
		// segment response, read back, unknown action, frame while idle,
		// expedited read, start while busy, abort and timeout
		load(8'h00);
		load(8'hFF);
		start(1, 7'h7F, 16'hFFFF, 8'hFF);
		reply(8'h60);
		tick(8'd0);
		tick(8'd1);
		send(any_request(3'd7));
		reply(8'h43);
		start(1, 7'h00, 16'h0000, 8'h00);
		reply(8'h20);
		start(0, 7'h05, 16'h1018, 8'h01);
		start(1, 7'h06, 16'h2000, 8'h00);
		reply(8'h43);
		start(0, 7'h22, 16'h6000, 8'h02);
		reply(CS_ABORT);
		start(0, 7'h41, 16'h1000, 8'h00);
		repeat (10) tick(8'd0);

		run_until(250, 1);
		set_timeout(13'd5000);
		run_until(550, 0);
		set_timeout(13'($urandom_range(10, 5000)));
		run_until(850, 1);
		set_timeout(TIMEOUT_RESET);
		run_until(1100, 0);

		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
